/* design/queue_from_two_stacks_assert.svh */
// Assertion macros used by qts_back in the queue_from_two_stacks RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef QUEUE_FROM_TWO_STACKS_ASSERT_SVH
`define QUEUE_FROM_TWO_STACKS_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define QTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define QTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/qts_pkg.sv */
// Package for the two-stack queue: command codes, payload structs, constants.
// No dependencies.
package qts_pkg;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ   = 3'd0,
        CMD_DEQ   = 3'd1,
        CMD_FRONT = 3'd2,
        CMD_BACK  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    localparam logic signed [DATA_W-1:0] FAIL_WORD = -32'sd1;
    localparam logic signed [DATA_W-1:0] ZERO_WORD = 32'sd0;

    // Input transaction
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     ok;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_out;

    // Decoded command handed from the front end to the execution side.
    // No flag set means an unknown code.
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic                     front;
        logic                     back;
        logic                     clr;
        logic signed [DATA_W-1:0] value;
    } t_op;

endpackage

/* design/queue_from_two_stacks.sv */
// Top level of the two-stack queue: front end plus execution side.
// Depends on qts_pkg, qts_front, qts_back (and qts_ram below it).
//
// FIFO queue held in two bounded stacks of STACK_DEPTH 32-bit words each,
// an inbox and an outbox, each in its own single-port-read RAM. Every input
// transaction (enqueue, dequeue, read front, read back, clear) gives exactly
// one result transaction with data, ok, the entry count after the operation
// and an empty flag. Enqueue fails when the inbox is full even if the outbox
// has room. Dequeue and read front move the whole inbox onto the outbox when
// the outbox is empty. The front end decodes commands into a two-entry
// buffer, so input is taken while the execution side works or while a
// result waits in the output register. Steps per transaction on the
// execution side: enqueue, clear, unknown codes and any failing command are
// done in the idle state; read back, and dequeue or read front with a
// nonempty outbox, go through address, registered RAM read and result; a
// dequeue or read front that finds the outbox empty first runs a refill,
// one word per cycle through the inbox read port and the outbox write
// port. Decoded commands are registered in the buffer. No clearing pass
// runs after reset; stored words are never read before they are written.
module queue_from_two_stacks
    import qts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_ready
);

    // decoded command buffer between the two halves
    logic q_valid;
    logic q_pop;
    t_op  q_op;

    // accept and decode transactions
    qts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_q_valid  (q_valid),
        .o_q_op     (q_op),
        .i_q_pop    (q_pop)
    );

    // execute against the stacks and hold the result until taken
    qts_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/qts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/qts_front.sv */
// Front end: accept input transactions, decode the command, buffer them.
// Depends on qts_pkg.
module qts_front
    import qts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    output logic o_q_valid,
    output t_op  o_q_op,
    input  logic i_q_pop
);

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    t_op            r_slot [QD];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] n_wr;
    logic [QAW-1:0] n_rd;
    logic [QCW-1:0] n_cnt;
    logic           push;
    logic           pop;
    t_op            dec;

    // decode the command into one flag per operation
    always_comb begin
        dec       = '0;
        dec.value = i_in_data.value;
        case (i_in_data.cmd)
            CMD_ENQ:   dec.enq   = 1'b1;
            CMD_DEQ:   dec.deq   = 1'b1;
            CMD_FRONT: dec.front = 1'b1;
            CMD_BACK:  dec.back  = 1'b1;
            CMD_CLEAR: dec.clr   = 1'b1;
            default:   dec.enq   = 1'b0;
        endcase
    end

    assign o_in_ready = (r_cnt != QCW'(QD));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_op     = r_slot[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wr  = push ? r_wr + QAW'(1) : r_wr;
        n_rd  = pop ? r_rd + QAW'(1) : r_rd;
        n_cnt = r_cnt + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* design/qts_back.sv */
// Execution side: inbox and outbox stacks, refill sequencer, result register.
// Depends on qts_pkg, qts_ram and the assertion macro header.
`include "queue_from_two_stacks_assert.svh"
module qts_back
    import qts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_op  i_q_op,
    output logic o_q_pop,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_out o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_XFER  = 4'b0010,
        S_RADDR = 4'b0100,
        S_RDATA = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_ic, n_ic;
    logic [CW-1:0] r_oc, n_oc;
    t_op     r_op, n_op;
    logic    r_mv_valid, n_mv_valid;
    logic    r_src_out, n_src_out;
    logic    r_out_valid, n_out_valid;
    t_out    r_out, n_out;

    logic [CW-1:0]        ic_dec;
    logic [CW-1:0]        oc_dec;
    logic                 out_free;
    logic                 load;
    logic signed [DATA_W-1:0] res_data;
    logic                 res_ok;
    logic [TW-1:0]        total;
    logic [TW+COUNT_W-1:0] total_wide;

    logic              in_we, in_re, ob_we, ob_re;
    logic [AW-1:0]     in_waddr, in_raddr, ob_waddr, ob_raddr;
    logic [DATA_W-1:0] in_wdata, in_rdata, ob_wdata, ob_rdata;

    qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_inbox (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (in_wdata),
        .i_re    (in_re),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_outbox (
        .i_clk   (i_clk),
        .i_we    (ob_we),
        .i_waddr (ob_waddr),
        .i_wdata (ob_wdata),
        .i_re    (ob_re),
        .i_raddr (ob_raddr),
        .o_rdata (ob_rdata)
    );

    assign ic_dec   = r_ic - CW'(1);
    assign oc_dec   = r_oc - CW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_ic        = r_ic;
        n_oc        = r_oc;
        n_op        = r_op;
        n_mv_valid  = r_mv_valid;
        n_src_out   = r_src_out;
        o_q_pop     = 1'b0;
        load        = 1'b0;
        res_data    = FAIL_WORD;
        res_ok      = 1'b0;
        in_we       = 1'b0;
        in_waddr    = r_ic[AW-1:0];
        in_wdata    = i_q_op.value;
        in_re       = 1'b0;
        in_raddr    = ic_dec[AW-1:0];
        ob_we       = 1'b0;
        ob_waddr    = r_oc[AW-1:0];
        ob_wdata    = in_rdata;
        ob_re       = 1'b0;
        ob_raddr    = oc_dec[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_op.enq) begin
                        if (out_free) begin
                            o_q_pop = 1'b1;
                            load    = 1'b1;
                            // drop the word when the inbox is full
                            if (r_ic != FULL) begin
                                in_we    = 1'b1;
                                n_ic     = r_ic + CW'(1);
                                res_data = ZERO_WORD;
                                res_ok   = 1'b1;
                            end
                        end
                    end else if (i_q_op.clr) begin
                        if (out_free) begin
                            o_q_pop  = 1'b1;
                            load     = 1'b1;
                            n_ic     = '0;
                            n_oc     = '0;
                            res_data = ZERO_WORD;
                            res_ok   = 1'b1;
                        end
                    end else if ((i_q_op.deq || i_q_op.front || i_q_op.back)
                                 && (r_ic != '0 || r_oc != '0)) begin
                        o_q_pop   = 1'b1;
                        n_op      = i_q_op;
                        n_src_out = i_q_op.deq || i_q_op.front || (r_ic == '0);
                        if (!i_q_op.back && r_oc == '0) begin
                            n_state    = S_XFER;
                            n_mv_valid = 1'b0;
                        end else begin
                            n_state = S_RADDR;
                        end
                    end else if (out_free) begin
                        // empty queue or unknown code
                        o_q_pop = 1'b1;
                        load    = 1'b1;
                    end
                end
            end
            S_XFER: begin
                // write the word read last cycle, read the next inbox top
                if (r_mv_valid) begin
                    ob_we = 1'b1;
                    n_oc  = r_oc + CW'(1);
                end
                if (r_ic != '0) begin
                    in_re      = 1'b1;
                    n_ic       = ic_dec;
                    n_mv_valid = 1'b1;
                end else begin
                    n_mv_valid = 1'b0;
                    if (!r_mv_valid) begin
                        n_state = S_RADDR;
                    end
                end
            end
            S_RADDR: begin
                if (r_src_out) begin
                    ob_re = 1'b1;
                    if (r_op.back) begin
                        ob_raddr = '0;
                    end
                end else begin
                    in_re = 1'b1;
                end
                n_state = S_RDATA;
            end
            S_RDATA: begin
                if (out_free) begin
                    load     = 1'b1;
                    res_ok   = 1'b1;
                    res_data = r_src_out ? ob_rdata : in_rdata;
                    if (r_op.deq) begin
                        n_oc = oc_dec;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register; counts come from the post-operation values
    always_comb begin
        total      = TW'(n_ic) + TW'(n_oc);
        total_wide = (TW + COUNT_W)'(total);
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (load) begin
            n_out_valid    = 1'b1;
            n_out.data     = res_data;
            n_out.ok       = res_ok;
            n_out.count    = total_wide[COUNT_W-1:0];
            n_out.is_empty = (total == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_src_out <= n_src_out;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ic        <= '0;
            r_oc        <= '0;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ic        <= n_ic;
            r_oc        <= n_oc;
            r_mv_valid  <= n_mv_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the word in flight between the two RAMs counts toward the total
    `QTS_ASSERT_NEXT(a_xfer_keeps_total, r_state == S_XFER,
        (TW'(r_ic) + TW'(r_oc) + TW'(r_mv_valid)) == (TW'($past(r_ic)) + TW'($past(r_oc)) + TW'($past(r_mv_valid))),
        "refill changed the entry count")
    `QTS_ASSERT_NEXT(a_xfer_ends_full, (r_state == S_XFER) && (n_state == S_RADDR),
        (r_ic == '0) && (r_oc != '0), "refill ended with inbox left or outbox empty")
    `QTS_ASSERT_NOW(a_read_nonempty, r_state == S_RADDR,
        (r_src_out && r_oc != '0) || (!r_src_out && r_ic != '0),
        "stack read issued on an empty stack")

endmodule
